// File: design/btq_pkg.sv
// ----------------------------------------------------------------------------
// btq_pkg
// Shared types and constants for the button trigger qualifier.
// ----------------------------------------------------------------------------
package btq_pkg;

   localparam int NumButtons     = 7;
   localparam int SwitchW        = 7;
   localparam int HighTimeW      = 8;
   localparam int LowTimeW       = 12;
   localparam int CodeW          = 3;
   localparam int ActionW        = 2;
   localparam int CsrIndexW      = 4;
   localparam int CsrDataW       = 12;

   localparam logic [HighTimeW-1:0] HighSaturation   = 8'd250;
   localparam logic [HighTimeW-1:0] MinHighReset     = 8'd10;
   localparam logic [LowTimeW-1:0]  LongPressReset   = 12'd1333;

   localparam logic [ActionW-1:0] ActTick   = 2'd0;
   localparam logic [ActionW-1:0] ActGroupA = 2'd1;
   localparam logic [ActionW-1:0] ActGroupB = 2'd2;

   localparam logic [CsrIndexW-1:0] RegMinHigh   = 4'd0;
   localparam logic [CsrIndexW-1:0] RegLongPress = 4'd1;

   typedef struct packed {
      logic [CodeW-1:0] trigger_code;
      logic             bank_select_press;
      logic             long_press;
   } rsp_type;

   typedef struct packed {
      logic                 write;
      logic [CsrIndexW-1:0] index;
      logic [CsrDataW-1:0]  data;
   } csr_wr_type;

endpackage

// File: design/btq_if.sv
// ----------------------------------------------------------------------------
// btq_if
// Valid/ready channel interfaces for request, response and register beats.
// ----------------------------------------------------------------------------
interface btq_req_if;
   logic                          valid;
   logic                          ready;
   logic [btq_pkg::ActionW-1:0]   action;
   logic [btq_pkg::SwitchW-1:0]   switch_levels;

   modport source (output valid, action, switch_levels, input ready);
   modport sink   (input valid, action, switch_levels, output ready);
endinterface

interface btq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [btq_pkg::CodeW-1:0]     trigger_code;
   logic                          bank_select_press;
   logic                          long_press;

   modport source (output valid, trigger_code, bank_select_press, long_press, input ready);
   modport sink   (input valid, trigger_code, bank_select_press, long_press, output ready);
endinterface

interface btq_csr_if;
   logic                          valid;
   logic                          ready;
   logic [btq_pkg::CsrIndexW-1:0] index;
   logic [btq_pkg::CsrDataW-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/btq_engine.sv
// ----------------------------------------------------------------------------
// btq_engine
// Button counters, long-press timer and press qualification for one beat.
// ----------------------------------------------------------------------------
module btq_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [btq_pkg::ActionW-1:0]   action,
   input  logic [btq_pkg::SwitchW-1:0]   levels,
   input  btq_pkg::csr_wr_type           csr_wr,
   output btq_pkg::rsp_type              result
);

   logic [btq_pkg::HighTimeW-1:0] high_time_ff [btq_pkg::NumButtons];
   logic [btq_pkg::HighTimeW-1:0] high_time_in [btq_pkg::NumButtons];
   logic [btq_pkg::LowTimeW-1:0]  low_time_ff, low_time_in;
   logic [btq_pkg::HighTimeW-1:0] min_high_ff;
   logic [btq_pkg::LowTimeW-1:0]  long_press_ff;
   logic [btq_pkg::NumButtons-1:0] pressed;
   logic [btq_pkg::NumButtons-1:0] qual;

   always_comb begin
      for (int i = 0; i < btq_pkg::NumButtons; i++) begin
         if (i < btq_pkg::SwitchW) begin
            pressed[i] = !levels[i];
         end else begin
            pressed[i] = 1'b1;
         end
         qual[i] = pressed[i] && (high_time_ff[i] >= min_high_ff);
      end
   end

   always_comb begin
      logic found;
      found        = 1'b0;
      high_time_in = high_time_ff;
      low_time_in  = low_time_ff;
      result       = '0;
      unique case (action)
         btq_pkg::ActTick: begin
            for (int i = 0; i < btq_pkg::NumButtons; i++) begin
               if (!pressed[i] && high_time_ff[i] < btq_pkg::HighSaturation) begin
                  high_time_in[i] = high_time_ff[i] + 1'b1;
               end
            end
            if (!pressed[0]) begin
               low_time_in = '0;
            end else if (low_time_ff < long_press_ff) begin
               low_time_in = low_time_ff + 1'b1;
            end else begin
               result.long_press = 1'b1;
            end
         end
         btq_pkg::ActGroupA: begin
            priority if (qual[1]) begin
               result.trigger_code = btq_pkg::CodeW'(1);
               high_time_in[1]     = '0;
            end else if (qual[2]) begin
               result.trigger_code = btq_pkg::CodeW'(2);
               high_time_in[2]     = '0;
            end
         end
         btq_pkg::ActGroupB: begin
            if (qual[0]) begin
               result.bank_select_press = 1'b1;
               high_time_in[0]          = '0;
            end else begin
               for (int i = 3; i < btq_pkg::NumButtons; i++) begin
                  if (!found && qual[i]) begin
                     found               = 1'b1;
                     result.trigger_code = btq_pkg::CodeW'(i);
                     high_time_in[i]     = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < btq_pkg::NumButtons; i++) begin
            high_time_ff[i] <= '0;
         end
         low_time_ff <= '0;
      end else if (fire) begin
         high_time_ff <= high_time_in;
         low_time_ff  <= low_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_high_ff   <= btq_pkg::MinHighReset;
         long_press_ff <= btq_pkg::LongPressReset;
      end else if (csr_wr.write) begin
         if (csr_wr.index == btq_pkg::RegMinHigh) begin
            min_high_ff <= csr_wr.data[btq_pkg::HighTimeW-1:0];
         end else if (csr_wr.index == btq_pkg::RegLongPress) begin
            long_press_ff <= csr_wr.data[btq_pkg::LowTimeW-1:0];
         end
      end
   end

   a_tick_no_code: assert property (@(posedge clock) disable iff (reset)
      (fire && action == btq_pkg::ActTick) |-> (result.trigger_code == '0
                                               && !result.bank_select_press))
      else $error("tick beat reported a press");

   a_low_time_bound: assert property (@(posedge clock) disable iff (reset)
      (fire && action == btq_pkg::ActTick && !csr_wr.write
       && low_time_ff <= long_press_ff) |=> (low_time_ff <= long_press_ff))
      else $error("held time passed the long-press limit");

   a_press_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && result.bank_select_press) |=> (high_time_ff[0] == '0))
      else $error("bank-select counter not cleared after a qualified press");

endmodule

// File: design/button_trigger_qualifier_core.sv
// ----------------------------------------------------------------------------
// button_trigger_qualifier_core
// Push-button qualifier: saturating released-time counters, bank-select
// long-press timer and first-qualified-press reporting per pin group.
//
//   channel  dir  handshake      payload
//   req_bus  in   valid/ready    action, switch_levels
//   rsp_bus  out  valid/ready    trigger_code, bank_select_press, long_press
//   csr_bus  in   valid/ready    index, data (always ready)
//
// One request beat per cycle while req ready is high; its response leads the
// buffer the cycle after when none waits. Responses sit in a two-entry buffer,
// so requests keep flowing while one response waits; req ready drops only
// when both entries are full. Sync reset restores counters and registers; no clearing pass.
// ----------------------------------------------------------------------------
module button_trigger_qualifier_core (
   input  logic      clock,
   input  logic      reset,
   btq_req_if.sink   req_bus,
   btq_rsp_if.source rsp_bus,
   btq_csr_if.sink   csr_bus
);

   btq_pkg::rsp_type    result;
   btq_pkg::csr_wr_type csr_wr;
   btq_pkg::rsp_type    slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]          count_ff, count_in;
   logic                push, pop;

   assign csr_bus.ready = 1'b1;
   assign csr_wr.write  = csr_bus.valid;
   assign csr_wr.index  = csr_bus.index;
   assign csr_wr.data   = csr_bus.data;

   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;

   btq_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (push),
      .action (req_bus.action),
      .levels (req_bus.switch_levels),
      .csr_wr (csr_wr),
      .result (result)
   );

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      unique case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = result;
            end else begin
               slot1_in = result;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = result;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = result;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_bus.valid             = (count_ff != 2'd0);
   assign rsp_bus.trigger_code      = slot0_ff.trigger_code;
   assign rsp_bus.bank_select_press = slot0_ff.bank_select_press;
   assign rsp_bus.long_press        = slot0_ff.long_press;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response buffer overflow");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> (count_ff == 2'd2))
      else $error("full buffer lost an entry");

   a_exclusive_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.long_press) |->
         (rsp_bus.trigger_code == '0 && !rsp_bus.bank_select_press))
      else $error("long press reported with a button press");

   a_push_seen: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("accepted beat not buffered");

endmodule
